/* rtl/core/lwws_pkg.sv */
// Shared types and constants for the LCD window write sequencer.
// Used by the front end, the job queue, the back end and the top level.
package lwws_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_FILL  = 2'd0;
    localparam logic [1:0] KIND_MAP   = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd480;
    localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd320;

    // Display bus command words and the byte mask.
    localparam logic [15:0] CMD_COL_SET = 16'h002A;
    localparam logic [15:0] CMD_ROW_SET = 16'h002B;
    localparam logic [15:0] CMD_MEM_WR  = 16'h002C;
    localparam logic [15:0] BYTE_MASK   = 16'h00FF;

    // Work handed from the front end to the back end.
    typedef enum logic [1:0] {
        JOB_FILL,
        JOB_MAP,
        JOB_PIXEL
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [11:0] left;
        logic [11:0] right;
        logic [11:0] top;
        logic [11:0] bottom;
        logic [15:0] color;
    } job_t;

endpackage

/* rtl/core/lwws_front.sv */
// Front end: accepts items, holds the screen size and the map window state,
// clips rectangles and pushes jobs into the queue. Depends on lwws_pkg.
module lwws_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        kind,
    input  logic signed [15:0]                x_first,
    input  logic signed [15:0]                y_first,
    input  logic signed [15:0]                x_final,
    input  logic signed [15:0]                y_final,
    input  logic [15:0]                       pixel_color,
    input  logic                              cfg_valid,
    input  logic [lwws_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [11:0]                       cfg_data,
    input  logic                              queue_full,
    output logic                              push,
    output lwws_pkg::job_t                    push_job
);
    import lwws_pkg::*;

    logic [11:0]        screen_width_reg, screen_width_next;
    logic [11:0]        screen_height_reg, screen_height_next;
    logic               window_open_reg, window_open_next;
    logic signed [15:0] source_left_reg, source_left_next;
    logic signed [15:0] source_right_reg, source_right_next;
    logic [11:0]        clip_left_reg, clip_left_next;
    logic [11:0]        clip_right_reg, clip_right_next;
    logic [11:0]        clip_top_reg, clip_top_next;
    logic [11:0]        clip_bottom_reg, clip_bottom_next;
    logic signed [15:0] cursor_x_reg, cursor_x_next;
    logic signed [15:0] cursor_y_reg, cursor_y_next;

    logic               accept;
    logic signed [16:0] wmax, hmax;
    logic signed [16:0] x1_ext, y1_ext, x2_ext, y2_ext;
    logic               off_screen;
    logic [11:0]        lft, rgt, tp, bot;
    logic               in_clip;
    logic signed [15:0] cursor_y_inc;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign wmax   = $signed({5'b0, screen_width_reg}) - 17'sd1;
    assign hmax   = $signed({5'b0, screen_height_reg}) - 17'sd1;
    assign x1_ext = {x_first[15], x_first};
    assign y1_ext = {y_first[15], y_first};
    assign x2_ext = {x_final[15], x_final};
    assign y2_ext = {y_final[15], y_final};

    assign off_screen = (screen_width_reg == 12'd0) || (screen_height_reg == 12'd0) ||
                        x_final[15] || y_final[15] ||
                        (x1_ext > wmax) || (y1_ext > hmax) ||
                        (x_final < x_first) || (y_final < y_first);

    // Once the rectangle is known to touch the screen, each corner fits 12 bits.
    assign lft = x_first[15] ? 12'd0 : x_first[11:0];
    assign tp  = y_first[15] ? 12'd0 : y_first[11:0];
    assign rgt = (x2_ext > wmax) ? wmax[11:0] : x_final[11:0];
    assign bot = (y2_ext > hmax) ? hmax[11:0] : y_final[11:0];

    // The clip bounds never exceed 4094, so they compare as positive 16-bit values.
    assign in_clip = (cursor_x_reg >= $signed({4'b0, clip_left_reg})) &&
                     (cursor_x_reg <= $signed({4'b0, clip_right_reg})) &&
                     (cursor_y_reg >= $signed({4'b0, clip_top_reg})) &&
                     (cursor_y_reg <= $signed({4'b0, clip_bottom_reg}));

    assign cursor_y_inc = cursor_y_reg + 16'sd1;

    always_comb
    begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        window_open_next   = window_open_reg;
        source_left_next   = source_left_reg;
        source_right_next  = source_right_reg;
        clip_left_next     = clip_left_reg;
        clip_right_next    = clip_right_reg;
        clip_top_next      = clip_top_reg;
        clip_bottom_next   = clip_bottom_reg;
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        push               = 1'b0;
        push_job.kind      = JOB_PIXEL;
        push_job.left      = lft;
        push_job.right     = rgt;
        push_job.top       = tp;
        push_job.bottom    = bot;
        push_job.color     = pixel_color;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_next  = cfg_data;
                REG_SCREEN_HEIGHT: screen_height_next = cfg_data;
                default:           ;
            endcase
        end

        if (accept)
        begin
            case (kind)
                KIND_FILL:
                begin
                    if (!off_screen)
                    begin
                        push          = 1'b1;
                        push_job.kind = JOB_FILL;
                    end
                end
                KIND_MAP:
                begin
                    if (off_screen)
                    begin
                        window_open_next = 1'b0;
                    end
                    else
                    begin
                        push              = 1'b1;
                        push_job.kind     = JOB_MAP;
                        window_open_next  = 1'b1;
                        source_left_next  = x_first;
                        source_right_next = x_final;
                        clip_left_next    = lft;
                        clip_right_next   = rgt;
                        clip_top_next     = tp;
                        clip_bottom_next  = bot;
                        cursor_x_next     = x_first;
                        cursor_y_next     = y_first;
                    end
                end
                KIND_PIXEL:
                begin
                    if (window_open_reg)
                    begin
                        push = in_clip;
                        // The cursor walks the whole requested width, clipped or not.
                        if (cursor_x_reg >= source_right_reg)
                        begin
                            cursor_x_next = source_left_reg;
                            cursor_y_next = cursor_y_inc;
                            if (cursor_y_inc > $signed({4'b0, clip_bottom_reg}))
                            begin
                                window_open_next = 1'b0;
                            end
                        end
                        else
                        begin
                            cursor_x_next = cursor_x_reg + 16'sd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
            window_open_reg   <= 1'b0;
            source_left_reg   <= '0;
            source_right_reg  <= '0;
            clip_left_reg     <= '0;
            clip_right_reg    <= '0;
            clip_top_reg      <= '0;
            clip_bottom_reg   <= '0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
        end
        else
        begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            window_open_reg   <= window_open_next;
            source_left_reg   <= source_left_next;
            source_right_reg  <= source_right_next;
            clip_left_reg     <= clip_left_next;
            clip_right_reg    <= clip_right_next;
            clip_top_reg      <= clip_top_next;
            clip_bottom_reg   <= clip_bottom_next;
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
        end
    end

endmodule

/* rtl/core/lwws_queue.sv */
// Short first-in first-out job queue between the front and back ends.
// Depends on lwws_pkg for the job type.
module lwws_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lwws_pkg::job_t push_job,
    input  logic           pop,
    output lwws_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);
    import lwws_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/lwws_back.sv */
// Back end: takes jobs from the queue and emits bus words through a registered
// output stage, one word per cycle while out_ready allows. Depends on lwws_pkg.
module lwws_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           queue_empty,
    input  lwws_pkg::job_t head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           is_data,
    output logic [15:0]    bus_word,
    output logic [23:0]    copies,
    output logic           run_end
);
    import lwws_pkg::*;

    typedef enum logic {
        BK_IDLE,
        BK_FRAME
    } back_state_t;

    localparam logic [3:0] STEP_COL_L_HI = 4'd1;
    localparam logic [3:0] STEP_COL_L_LO = 4'd2;
    localparam logic [3:0] STEP_COL_R_HI = 4'd3;
    localparam logic [3:0] STEP_COL_R_LO = 4'd4;
    localparam logic [3:0] STEP_ROW_SET  = 4'd5;
    localparam logic [3:0] STEP_ROW_T_HI = 4'd6;
    localparam logic [3:0] STEP_ROW_T_LO = 4'd7;
    localparam logic [3:0] STEP_ROW_B_HI = 4'd8;
    localparam logic [3:0] STEP_ROW_B_LO = 4'd9;
    localparam logic [3:0] STEP_MEM_WR   = 4'd10;
    localparam logic [3:0] STEP_BURST    = 4'd11;

    back_state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    job_t        job_reg, job_next;
    logic [11:0] span_x_reg, span_x_next;
    logic [11:0] span_y_reg, span_y_next;
    logic [23:0] count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    logic        is_data_reg, is_data_next;
    logic [15:0] bus_word_reg, bus_word_next;
    logic [23:0] copies_reg, copies_next;
    logic        run_end_reg, run_end_next;
    logic        out_load;

    assign out_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign is_data   = is_data_reg;
    assign bus_word  = bus_word_reg;
    assign copies    = copies_reg;
    assign run_end   = run_end_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        job_next       = job_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        // The pixel count is ready long before the burst word goes out.
        count_next     = span_x_reg * span_y_reg;
        out_valid_next = out_valid_reg && !out_ready;
        is_data_next   = is_data_reg;
        bus_word_next  = bus_word_reg;
        copies_next    = copies_reg;
        run_end_next   = run_end_reg;
        pop            = 1'b0;

        if (out_load)
        begin
            case (state_reg)
                BK_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        copies_next    = 24'd1;
                        if (head_job.kind == JOB_PIXEL)
                        begin
                            is_data_next  = 1'b1;
                            bus_word_next = head_job.color;
                            run_end_next  = 1'b1;
                        end
                        else
                        begin
                            is_data_next  = 1'b0;
                            bus_word_next = CMD_COL_SET;
                            run_end_next  = 1'b0;
                            job_next      = head_job;
                            span_x_next   = head_job.right - head_job.left + 12'd1;
                            span_y_next   = head_job.bottom - head_job.top + 12'd1;
                            step_next     = STEP_COL_L_HI;
                            state_next    = BK_FRAME;
                        end
                    end
                end
                BK_FRAME:
                begin
                    out_valid_next = 1'b1;
                    is_data_next   = 1'b1;
                    copies_next    = 24'd1;
                    run_end_next   = 1'b0;
                    step_next      = step_reg + 4'd1;
                    case (step_reg)
                        STEP_COL_L_HI: bus_word_next = {12'd0, job_reg.left[11:8]};
                        STEP_COL_L_LO: bus_word_next = {4'd0, job_reg.left} & BYTE_MASK;
                        STEP_COL_R_HI: bus_word_next = {12'd0, job_reg.right[11:8]};
                        STEP_COL_R_LO: bus_word_next = {4'd0, job_reg.right} & BYTE_MASK;
                        STEP_ROW_SET:
                        begin
                            is_data_next  = 1'b0;
                            bus_word_next = CMD_ROW_SET;
                        end
                        STEP_ROW_T_HI: bus_word_next = {12'd0, job_reg.top[11:8]};
                        STEP_ROW_T_LO: bus_word_next = {4'd0, job_reg.top} & BYTE_MASK;
                        STEP_ROW_B_HI: bus_word_next = {12'd0, job_reg.bottom[11:8]};
                        STEP_ROW_B_LO: bus_word_next = {4'd0, job_reg.bottom} & BYTE_MASK;
                        STEP_MEM_WR:
                        begin
                            is_data_next  = 1'b0;
                            bus_word_next = CMD_MEM_WR;
                            if (job_reg.kind != JOB_FILL)
                            begin
                                run_end_next = 1'b1;
                                state_next   = BK_IDLE;
                            end
                        end
                        STEP_BURST:
                        begin
                            // Fill burst: the color repeated over the clipped area.
                            bus_word_next = job_reg.color;
                            copies_next   = count_reg;
                            run_end_next  = 1'b1;
                            state_next    = BK_IDLE;
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                            state_next     = BK_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    state_next = BK_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            job_reg       <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            is_data_reg   <= 1'b0;
            bus_word_reg  <= '0;
            copies_reg    <= '0;
            run_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            job_reg       <= job_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            is_data_reg   <= is_data_next;
            bus_word_reg  <= bus_word_next;
            copies_reg    <= copies_next;
            run_end_reg   <= run_end_next;
        end
    end

endmodule

/* rtl/core/lcd_window_write_sequencer_unit.sv */
// Top level of the LCD window write sequencer: front end, job queue, back end.
// Depends on lwws_pkg, lwws_front, lwws_queue and lwws_back.
//
// This block turns rectangle requests into display bus words. A fill or map
// request that touches the screen is clipped and expands into the address
// window frame (column set with four bytes, row set with four bytes, memory
// write), followed for a fill by one burst word that carries the color and
// the pixel count. A map request opens a window; each later pixel item that
// falls inside the clipped area gives one data word, and a request that lies
// off screen gives nothing. The front end accepts one item per cycle whenever
// the job queue has room, so pixel items stream at one per cycle with one
// word out per cycle while out_ready holds. A frame is 11 bus words (12 for a
// fill), and the back end emits one bus word per cycle unless out_ready stalls
// it; pixels queued behind a frame wait for it, and the input stalls once
// QUEUE_DEPTH jobs are waiting. An item that produces output goes through the
// job queue register and then the output register, even when the back end has
// nothing ahead of it. The screen size registers are written through the
// configuration port, which is always ready; write them only while idle.
module lcd_window_write_sequencer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration writes: index 0 is screen width, index 1 is screen height.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lwws_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [11:0]                       cfg_data,
    // Request items.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        kind,
    input  logic signed [15:0]                x_first,
    input  logic signed [15:0]                y_first,
    input  logic signed [15:0]                x_final,
    input  logic signed [15:0]                y_final,
    input  logic [15:0]                       pixel_color,
    // Bus word items.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              is_data,
    output logic [15:0]                       bus_word,
    output logic [23:0]                       copies,
    output logic                              run_end
);
    import lwws_pkg::*;

    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head_job;

    // Register writes never stall.
    assign cfg_ready = 1'b1;

    // The front end owns the screen size and the map window cursor, so clipping
    // and cursor stepping happen in the cycle an item is accepted.
    lwws_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .x_first     (x_first),
        .y_first     (y_first),
        .x_final     (x_final),
        .y_final     (y_final),
        .pixel_color (pixel_color),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_full  (queue_full),
        .push        (push),
        .push_job    (push_job)
    );

    // The queue lets the front end keep taking pixels while a frame drains.
    lwws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // The back end sequences frames word by word and owns the output register.
    lwws_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_data     (is_data),
        .bus_word    (bus_word),
        .copies      (copies),
        .run_end     (run_end)
    );

endmodule
